@@ hdl/psts_pkg.sv @@
package psts_pkg;

    localparam int TAG_W   = 8;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;
    localparam int CNT_W   = 6;
    localparam int AVG_W   = 29;

    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_RUN     = 1'b1;
    localparam logic KIND_TASK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [TAG_W-1:0]   task_tag;
        logic [PRIO_W-1:0]  priority_req;
        logic [BURST_W-1:0] burst;
    } t_task;

    typedef struct packed {
        logic              kind;
        logic [TAG_W-1:0]  tag_out;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] response_time;
        logic [CNT_W-1:0]  task_count;
        logic [AVG_W-1:0]  avg_wait;
        logic [AVG_W-1:0]  avg_turnaround;
        logic [AVG_W-1:0]  avg_response;
        logic              overflow;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_SCAN,
        ST_EMIT,
        ST_DIV,
        ST_SUM
    } t_state;

endpackage

@@ hdl/psts_ifs.sv @@
interface psts_task_if import psts_pkg::*; ();
    logic  valid;
    logic  ready;
    t_task data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface psts_result_if import psts_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ hdl/priority_scheduler_with_timing_stats.sv @@
// Add item: accepted with no result; the block stays ready for the next item.
// Run item: each served task passes through the pick state, a scan of the stored
// slots (one memory read per cycle) and the emit state. Then a setup step in the pick
// state and two averages on the shared restoring divider with a DW-bit dividend (DW = 36
// at default parameters), then the summary; an empty run skips the divider. Synchronous
// active-low reset empties the store, clears the overflow flag and the output valid.
module priority_scheduler_with_timing_stats import psts_pkg::*; #(
    parameter int MAX_TASKS  = 32,
    parameter int BURST_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psts_task_if.sink    i_task,
    psts_result_if.source o_result
);

    // Stored burst width: the input field is 16 bits, so a wider setting adds nothing.
    localparam int SB  = (BURST_BITS < BURST_W) ? BURST_BITS : BURST_W;
    // Count width holds 0..MAX_TASKS; index width addresses the slots.
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    // Elapsed time and the total of waiting times, both kept at full width.
    localparam int EW  = SB + CW;
    localparam int TW  = SB + 2 * CW;
    // Dividend carries the eight fraction bits of the Q.8 averages.
    localparam int DW  = TW + 8;
    localparam int DCW = $clog2(DW);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [SB-1:0]     burst;
    } t_slot;

    // Slot store, written in arrival order and read one slot per cycle during a scan.
    t_slot r_mem [MAX_TASKS];
    t_slot r_rd_data;
    logic [IW-1:0] r_rd_idx;
    logic r_rd_vld;
    logic rd_en;
    logic [IW-1:0] rd_addr;
    logic wr_en;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_drop, n_drop;
    logic [MAX_TASKS-1:0] r_served, n_served;
    logic [CW-1:0] r_scan, n_scan;
    logic r_best_vld, n_best_vld;
    logic [IW-1:0] r_best_idx, n_best_idx;
    t_slot r_best, n_best;
    logic [EW-1:0] r_elapsed, n_elapsed;
    logic [TW-1:0] r_twt, n_twt;
    logic [CW-1:0] r_n, n_n;
    logic [DW-1:0] r_div_q, n_div_q;
    logic [CW-1:0] r_rem, n_rem;
    logic [DCW-1:0] r_div_cnt, n_div_cnt;
    logic r_div_sel, n_div_sel;
    logic [DW-1:0] r_avg_w, n_avg_w;
    logic [DW-1:0] r_avg_t, n_avg_t;
    t_result r_out, n_out;
    logic r_out_vld, n_out_vld;

    logic out_free;
    logic in_fire;
    logic [EW-1:0] tt_sum;
    logic [TW-1:0] ttt_sum;
    logic [CW:0] rem_sh;
    logic [CW:0] rem_diff;
    logic rem_ge;
    logic [DW-1:0] q_next;
    logic [EW+TIME_W-1:0] wt_ext;
    logic [EW+TIME_W-1:0] tt_ext;
    logic [CW+CNT_W-1:0] cnt_ext;
    logic [DW+AVG_W-1:0] avg_w_ext;
    logic [DW+AVG_W-1:0] avg_t_ext;

    assign i_task.ready   = (r_state == ST_IDLE);
    assign in_fire        = i_task.valid && (r_state == ST_IDLE);
    assign out_free       = !r_out_vld || o_result.ready;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    assign wr_en   = in_fire && (i_task.data.mode == MODE_ADD) && (r_count < CW'(MAX_TASKS));
    assign rd_en   = (r_state == ST_SCAN) && (r_scan < r_count);
    assign rd_addr = r_scan[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= '{tag:   i_task.data.task_tag,
                                        prio:  i_task.data.priority_req,
                                        burst: i_task.data.burst[SB-1:0]};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        r_rd_idx <= rd_addr;
    end

    // Arithmetic shared by the emit and divide steps.
    assign tt_sum    = r_elapsed + EW'(r_best.burst);
    assign ttt_sum   = r_twt + TW'(r_elapsed);
    assign rem_sh    = {r_rem, r_div_q[DW-1]};
    assign rem_ge    = (rem_sh >= {1'b0, r_n});
    assign rem_diff  = rem_sh - {1'b0, r_n};
    assign q_next    = {r_div_q[DW-2:0], rem_ge};

    // Zero-extend then cut to the fixed output widths.
    assign wt_ext    = {{TIME_W{1'b0}}, r_elapsed};
    assign tt_ext    = {{TIME_W{1'b0}}, tt_sum};
    assign cnt_ext   = {{CNT_W{1'b0}}, r_n};
    assign avg_w_ext = {{AVG_W{1'b0}}, r_avg_w};
    assign avg_t_ext = {{AVG_W{1'b0}}, r_avg_t};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_served   = r_served;
        n_scan     = r_scan;
        n_best_vld = r_best_vld;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_elapsed  = r_elapsed;
        n_twt      = r_twt;
        n_n        = r_n;
        n_div_q    = r_div_q;
        n_rem      = r_rem;
        n_div_cnt  = r_div_cnt;
        n_div_sel  = r_div_sel;
        n_avg_w    = r_avg_w;
        n_avg_t    = r_avg_t;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_result.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_task.data.mode == MODE_ADD) begin
                        if (wr_en) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        n_elapsed = '0;
                        n_twt     = '0;
                        n_n       = '0;
                        n_state   = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                if (r_n == r_count) begin
                    if (r_n == '0) begin
                        n_avg_w = '0;
                        n_avg_t = '0;
                        n_state = ST_SUM;
                    end else begin
                        n_div_q   = {r_twt, 8'b0};
                        n_rem     = '0;
                        n_div_cnt = '0;
                        n_div_sel = 1'b0;
                        n_state   = ST_DIV;
                    end
                end else begin
                    n_scan     = '0;
                    n_best_vld = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_scan = r_scan + CW'(1);
                end
                // Strict compare over ascending slots keeps the earliest of equal priorities.
                if (r_rd_vld && !r_served[r_rd_idx]
                        && (!r_best_vld || (r_rd_data.prio > r_best.prio))) begin
                    n_best_vld = 1'b1;
                    n_best_idx = r_rd_idx;
                    n_best     = r_rd_data;
                end
                if (!rd_en && !r_rd_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld             = 1'b1;
                    n_out.kind            = KIND_TASK;
                    n_out.tag_out         = r_best.tag;
                    n_out.wait_time       = wt_ext[TIME_W-1:0];
                    n_out.turnaround_time = tt_ext[TIME_W-1:0];
                    n_out.response_time   = wt_ext[TIME_W-1:0];
                    n_out.task_count      = '0;
                    n_out.avg_wait        = '0;
                    n_out.avg_turnaround  = '0;
                    n_out.avg_response    = '0;
                    n_out.overflow        = r_drop;
                    n_out.last            = 1'b0;
                    n_served[r_best_idx]  = 1'b1;
                    n_twt                 = r_twt + TW'(r_elapsed);
                    n_elapsed             = tt_sum;
                    n_n                   = r_n + CW'(1);
                    n_state               = ST_PICK;
                end
            end
            ST_DIV: begin
                n_rem     = rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
                n_div_q   = q_next;
                n_div_cnt = r_div_cnt + DCW'(1);
                if (r_div_cnt == DCW'(DW - 1)) begin
                    if (!r_div_sel) begin
                        // Total turnaround is total waiting plus the final elapsed time.
                        n_avg_w   = q_next;
                        n_div_q   = {ttt_sum, 8'b0};
                        n_rem     = '0;
                        n_div_cnt = '0;
                        n_div_sel = 1'b1;
                    end else begin
                        n_avg_t = q_next;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    n_out_vld             = 1'b1;
                    n_out.kind            = KIND_SUMMARY;
                    n_out.tag_out         = '0;
                    n_out.wait_time       = '0;
                    n_out.turnaround_time = '0;
                    n_out.response_time   = '0;
                    n_out.task_count      = cnt_ext[CNT_W-1:0];
                    n_out.avg_wait        = avg_w_ext[AVG_W-1:0];
                    n_out.avg_turnaround  = avg_t_ext[AVG_W-1:0];
                    n_out.avg_response    = avg_w_ext[AVG_W-1:0];
                    n_out.overflow        = r_drop;
                    n_out.last            = 1'b1;
                    n_count               = '0;
                    n_drop                = 1'b0;
                    n_served              = '0;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_served  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_served  <= n_served;
            r_rd_vld  <= rd_en;
            r_out_vld <= n_out_vld;
        end
        r_scan     <= n_scan;
        r_best_vld <= n_best_vld;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_elapsed  <= n_elapsed;
        r_twt      <= n_twt;
        r_n        <= n_n;
        r_div_q    <= n_div_q;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_div_sel  <= n_div_sel;
        r_avg_w    <= n_avg_w;
        r_avg_t    <= n_avg_t;
        r_out      <= n_out;
    end

endmodule

@@ tb/testbench.sv @@
module testbench import psts_pkg::*; ();

    // The block is built at its default size: a 32-slot store and 16-bit bursts.
    localparam int STORE_DEPTH  = 32;
    localparam int BURST_KEEP   = 16;
    // The random part stops once this many items have been queued after the directed part.
    localparam int RANDOM_ITEMS = 320;
    // The longest run serves 32 tasks and then runs two divisions. The drain after the
    // last record is set well beyond that.
    localparam int DRAIN_CYCLES = 1500;
    // Roughly 25 runs of up to 33 records each, with random stalls on the records and
    // random gaps between items, make up the test.
    // The limit leaves ample margin above its length.
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    psts_task_if   task_bus();
    psts_result_if result_bus();

    priority_scheduler_with_timing_stats #(
        .MAX_TASKS (STORE_DEPTH),
        .BURST_BITS(BURST_KEEP)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_bus),
        .o_result(result_bus)
    );

    // Items that wait to be driven, and the records that the schedule predicts.
    t_task       pending_items[$];
    t_result     expected_records[$];
    int unsigned items_total;
    int unsigned items_taken;
    int unsigned fail_count;
    int unsigned cycle_count;

    // The testbench keeps its own copy of the task store. Slots are filled in arrival
    // order, so the first slot_fill entries are the live tasks.
    logic [TAG_W-1:0]   slot_tag_copy[STORE_DEPTH];
    logic [PRIO_W-1:0]  slot_prio_copy[STORE_DEPTH];
    logic [BURST_W-1:0] slot_burst_copy[STORE_DEPTH];
    int unsigned        slot_fill;
    logic               add_dropped;

    // Idle state of the sender and of the receiver. While a side is calm, it does not idle.
    int unsigned src_wait;
    int unsigned sink_stall;
    bit          src_calm;
    bit          sink_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Most gaps are absent or short. A few are long enough to back the block up.
    function automatic int unsigned idle_len(bit calm);
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted item to the store copy. For a run item, it queues the
    // per-task records in service order and then the summary record.
    function automatic void schedule_item(t_task it);
        bit                 served[STORE_DEPTH];
        longint unsigned    elapsed;
        longint unsigned    sum_wait;
        longint unsigned    sum_turn;
        longint unsigned    turn;
        int                 best;
        int                 i;
        int                 k;
        int unsigned        served_cnt;
        t_result            rec;

        if (it.mode == MODE_ADD) begin
            if (slot_fill < STORE_DEPTH) begin
                slot_tag_copy[slot_fill]   = it.task_tag;
                slot_prio_copy[slot_fill]  = it.priority_req;
                slot_burst_copy[slot_fill] = it.burst & BURST_W'((64'd1 << BURST_KEEP) - 1);
                slot_fill++;
            end else begin
                add_dropped = 1'b1;
            end
            return;
        end

        elapsed    = 0;
        sum_wait   = 0;
        sum_turn   = 0;
        served_cnt = 0;
        for (i = 0; i < STORE_DEPTH; i++) served[i] = 1'b0;

        for (k = 0; k < STORE_DEPTH; k++) begin
            // A strict comparison lets the earlier-added task win a tie in priority.
            best = -1;
            for (i = 0; i < int'(slot_fill); i++) begin
                if (!served[i] && (best < 0 || slot_prio_copy[i] > slot_prio_copy[best]))
                    best = i;
            end
            if (best < 0) break;
            served[best] = 1'b1;
            turn = elapsed + slot_burst_copy[best];

            rec                 = '0;
            rec.kind            = KIND_TASK;
            rec.tag_out         = slot_tag_copy[best];
            rec.wait_time       = TIME_W'(elapsed);
            rec.turnaround_time = TIME_W'(turn);
            rec.response_time   = TIME_W'(elapsed);
            rec.overflow        = add_dropped;
            expected_records.push_back(rec);

            sum_wait += elapsed;
            sum_turn += turn;
            elapsed  = turn;
            served_cnt++;
        end

        // Response time equals waiting time without preemption, so the two averages
        // match. An empty run reports zero averages.
        rec            = '0;
        rec.kind       = KIND_SUMMARY;
        rec.task_count = CNT_W'(served_cnt);
        if (served_cnt != 0) begin
            rec.avg_wait       = AVG_W'((sum_wait << 8) / served_cnt);
            rec.avg_turnaround = AVG_W'((sum_turn << 8) / served_cnt);
            rec.avg_response   = AVG_W'((sum_wait << 8) / served_cnt);
        end
        rec.overflow = add_dropped;
        rec.last     = 1'b1;
        expected_records.push_back(rec);

        // A run empties the store and clears the overflow flag.
        slot_fill   = 0;
        add_dropped = 1'b0;
    endfunction

    function automatic void field_match(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_record(t_result got);
        t_result want;
        if (expected_records.size() == 0) begin
            $error("record with nothing expected: kind %0d tag 0x%0h", got.kind, got.tag_out);
            fail_count++;
            return;
        end
        want = expected_records.pop_front();
        field_match("kind",            want.kind,            got.kind);
        field_match("tag_out",         want.tag_out,         got.tag_out);
        field_match("wait_time",       want.wait_time,       got.wait_time);
        field_match("turnaround_time", want.turnaround_time, got.turnaround_time);
        field_match("response_time",   want.response_time,   got.response_time);
        field_match("task_count",      want.task_count,      got.task_count);
        field_match("avg_wait",        want.avg_wait,        got.avg_wait);
        field_match("avg_turnaround",  want.avg_turnaround,  got.avg_turnaround);
        field_match("avg_response",    want.avg_response,    got.avg_response);
        field_match("overflow",        want.overflow,        got.overflow);
        field_match("last",            want.last,            got.last);
    endfunction

    function automatic void queue_add(logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                      logic [BURST_W-1:0] burst);
        t_task it;
        it.mode         = MODE_ADD;
        it.task_tag     = tag;
        it.priority_req = prio;
        it.burst        = burst;
        pending_items.push_back(it);
        items_total++;
    endfunction

    // The other fields of a run item mean nothing. They get random values so that the
    // block is seen to ignore them.
    function automatic void queue_run();
        t_task it;
        it.mode         = MODE_RUN;
        it.task_tag     = TAG_W'($urandom);
        it.priority_req = PRIO_W'($urandom);
        it.burst        = BURST_W'($urandom);
        pending_items.push_back(it);
        items_total++;
    endfunction

    // Sender: after an item is accepted, it waits out a random gap and then presents
    // the next item from the queue. The schedule is predicted at the edge of acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            task_bus.valid <= 1'b0;
            src_wait       <= 0;
        end else begin
            if (task_bus.valid && task_bus.ready) begin
                schedule_item(task_bus.data);
                items_taken++;
                if ($urandom_range(0, 19) == 0) src_calm <= !src_calm;
            end
            if (!task_bus.valid || task_bus.ready) begin
                if (src_wait != 0) begin
                    task_bus.valid <= 1'b0;
                    src_wait       <= src_wait - 1;
                end else if (pending_items.size() != 0) begin
                    task_bus.valid <= 1'b1;
                    task_bus.data  <= pending_items.pop_front();
                    src_wait       <= idle_len(src_calm);
                end else begin
                    task_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready drops for random stretches regardless of whether a record is
    // waiting, so stalls land on every phase of a run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            sink_stall       <= 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                check_record(result_bus.data);
                if ($urandom_range(0, 19) == 0) sink_calm <= !sink_calm;
            end
            if (sink_stall != 0) begin
                result_bus.ready <= 1'b0;
                sink_stall       <= sink_stall - 1;
            end else begin
                result_bus.ready <= 1'b1;
                sink_stall       <= idle_len(sink_calm);
            end
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_scheduler_with_timing_stats verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned n_adds;
        int unsigned j;
        bit          narrow;
        logic [BURST_W-1:0] burst;

        i_rst_n          = 1'b0;
        task_bus.valid   = 1'b0;
        task_bus.data    = '0;
        result_bus.ready = 1'b0;
        items_total      = 0;
        items_taken      = 0;
        fail_count       = 0;
        cycle_count      = 0;
        slot_fill        = 0;
        add_dropped      = 1'b0;
        src_calm         = 1'b0;
        sink_calm        = 1'b0;

        // Directed part. A run over the empty store after reset yields a summary of zeros.
        queue_run();
        // The extremes of every field, with ties at the top and at the bottom of the
        // priority range. The earlier-added task in each tie must be served first.
        queue_add(8'h00, 8'h00, 16'h0000);
        queue_add(8'hFF, 8'hFF, 16'hFFFF);
        queue_add(8'h5A, 8'hFF, 16'h0001);
        queue_add(8'hA5, 8'h00, 16'hFFFF);
        queue_add(8'h33, 8'h80, 16'h8000);
        queue_add(8'hCC, 8'h7F, 16'h7FFF);
        queue_run();
        // A run with a single task, and then a run that shows the store was emptied.
        queue_add(8'h96, 8'h01, 16'h1234);
        queue_run();
        queue_run();

        // Random part. Each sequence is a burst of adds that ends in a run. Some
        // sequences overfill the store to set the overflow flag, and some are bare runs.
        // Half of the sequences draw from only a few priorities so that ties are common.
        while (items_total < 11 + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)       n_adds = 0;
            else if (roll < 20) n_adds = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 5);
            else if (roll < 35) n_adds = $urandom_range(13, STORE_DEPTH);
            else                n_adds = $urandom_range(1, 12);
            narrow = $urandom_range(0, 1);
            for (j = 0; j < n_adds; j++) begin
                roll = $urandom_range(0, 9);
                if (roll == 0)      burst = '0;
                else if (roll == 1) burst = '1;
                else                burst = BURST_W'($urandom);
                queue_add(TAG_W'($urandom),
                          narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom),
                          burst);
            end
            queue_run();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is accepted and every predicted record has come back.
        // Then allow time for any stray record to appear.
        while (items_taken != items_total) @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("priority_scheduler_with_timing_stats verification clean");
        end else begin
            $display("priority_scheduler_with_timing_stats verification failed");
        end
        $finish;
    end

endmodule
